### sv/mke_pkg.sv
// shared types, microcode store and symbol table of the morse keying encoder
package mke_pkg;

    localparam int UNIT_W  = 8;
    localparam int PAD_W   = 10;
    localparam int DUR_W   = 11;
    localparam int SYM_W   = 5;
    localparam int CNT_W   = 3;
    localparam int PADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_UNIT_SIZE = 1'b0;
    localparam logic REG_PAD_LEN   = 1'b1;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_CHAR  = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
    } mke_in_t;

    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] duration;
        logic             last;
    } mke_out_t;

    typedef enum logic [2:0] {
        UA_IDLE,
        UA_PAD,
        UA_SPACE,
        UA_LGAP,
        UA_MARK,
        UA_SGAP
    } uaddr_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_PAD_NZ,
        C_GAP,
        C_NO_SYM,
        C_LAST_SYM
    } cond_t;

    typedef enum logic [2:0] {
        D_PAD,
        D_U1,
        D_U3,
        D_U7,
        D_SYM
    } dur_sel_t;

    typedef enum logic [1:0] {
        G_KEEP,
        G_CLR,
        G_SET
    } gap_op_t;

    typedef struct packed {
        logic     dispatch;
        cond_t    emit_cond;
        logic     level;
        dur_sel_t dur_sel;
        cond_t    last_cond;
        gap_op_t  gap_op;
        logic     shift;
        cond_t    jump_cond;
        uaddr_t   jump_addr;
        uaddr_t   next_addr;
    } ucode_t;

    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic [SYM_W-1:0] pat;   // first symbol in the msb, 1 is a dash
    } sym_code_t;

    function automatic ucode_t ucode_rom(input uaddr_t addr);
        ucode_t w;
        w = '{dispatch: 1'b0, emit_cond: C_NEVER, level: 1'b0, dur_sel: D_U1,
              last_cond: C_NEVER, gap_op: G_KEEP, shift: 1'b0, jump_cond: C_ALWAYS,
              jump_addr: UA_IDLE, next_addr: UA_IDLE};
        unique case (addr)
            UA_IDLE:
            begin
                w.dispatch  = 1'b1;
            end
            UA_PAD:
            begin
                w.emit_cond = C_PAD_NZ;
                w.dur_sel   = D_PAD;
                w.last_cond = C_ALWAYS;
                w.gap_op    = G_CLR;
            end
            UA_SPACE:
            begin
                w.emit_cond = C_ALWAYS;
                w.dur_sel   = D_U7;
                w.last_cond = C_ALWAYS;
                w.gap_op    = G_CLR;
            end
            UA_LGAP:
            begin
                w.emit_cond = C_GAP;
                w.dur_sel   = D_U3;
                w.last_cond = C_NO_SYM;
                w.gap_op    = G_SET;
                w.jump_cond = C_NO_SYM;
                w.next_addr = UA_MARK;
            end
            UA_MARK:
            begin
                w.emit_cond = C_ALWAYS;
                w.level     = 1'b1;
                w.dur_sel   = D_SYM;
                w.last_cond = C_LAST_SYM;
                w.shift     = 1'b1;
                w.jump_cond = C_LAST_SYM;
                w.next_addr = UA_SGAP;
            end
            UA_SGAP:
            begin
                w.emit_cond = C_ALWAYS;
                w.dur_sel   = D_U1;
                w.jump_addr = UA_MARK;
            end
            default:
            begin
                w.dispatch  = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic sym_code_t sym_lookup(input logic [7:0] ch);
        sym_code_t s;
        s = '{len: 3'd0, pat: 5'b00000};
        case (ch)
            "A": s = '{len: 3'd2, pat: 5'b01000};
            "B": s = '{len: 3'd4, pat: 5'b10000};
            "C": s = '{len: 3'd4, pat: 5'b10100};
            "D": s = '{len: 3'd3, pat: 5'b10000};
            "E": s = '{len: 3'd1, pat: 5'b00000};
            "F": s = '{len: 3'd4, pat: 5'b00100};
            "G": s = '{len: 3'd3, pat: 5'b11000};
            "H": s = '{len: 3'd4, pat: 5'b00000};
            "I": s = '{len: 3'd2, pat: 5'b00000};
            "J": s = '{len: 3'd4, pat: 5'b01110};
            "K": s = '{len: 3'd3, pat: 5'b10100};
            "L": s = '{len: 3'd4, pat: 5'b01000};
            "M": s = '{len: 3'd2, pat: 5'b11000};
            "N": s = '{len: 3'd2, pat: 5'b10000};
            "O": s = '{len: 3'd3, pat: 5'b11100};
            "P": s = '{len: 3'd4, pat: 5'b01100};
            "Q": s = '{len: 3'd4, pat: 5'b11010};
            "R": s = '{len: 3'd3, pat: 5'b01000};
            "S": s = '{len: 3'd3, pat: 5'b00000};
            "T": s = '{len: 3'd1, pat: 5'b10000};
            "U": s = '{len: 3'd3, pat: 5'b00100};
            "V": s = '{len: 3'd4, pat: 5'b00010};
            "W": s = '{len: 3'd3, pat: 5'b01100};
            "X": s = '{len: 3'd4, pat: 5'b10010};
            "Y": s = '{len: 3'd4, pat: 5'b10110};
            "Z": s = '{len: 3'd4, pat: 5'b11000};
            "0": s = '{len: 3'd5, pat: 5'b11111};
            "1": s = '{len: 3'd5, pat: 5'b01111};
            "2": s = '{len: 3'd5, pat: 5'b00111};
            "3": s = '{len: 3'd5, pat: 5'b00011};
            "4": s = '{len: 3'd5, pat: 5'b00001};
            "5": s = '{len: 3'd5, pat: 5'b00000};
            "6": s = '{len: 3'd5, pat: 5'b10000};
            "7": s = '{len: 3'd5, pat: 5'b11000};
            "8": s = '{len: 3'd5, pat: 5'b11100};
            "9": s = '{len: 3'd5, pat: 5'b11110};
            default: s = '{len: 3'd0, pat: 5'b00000};
        endcase
        return s;
    endfunction

endpackage

### sv/morse_keying_encoder_top.sv
// morse keying encoder: microcoded sequencer, symbol latch and segment output register
//
// in channel (in_valid/in_ready/in_data): one transaction per request, a start of
// message, a character or an end of message. out channel (out_valid/out_ready/
// out_data): keying segments, each a level and a duration in signal bits, with
// last set on the final segment caused by a request. a request that causes no
// segment (zero pad, unused request type) just returns the sequencer to idle.
// apb port: unit size at 0x0, pad_len at 0x4, written with pready tied high.
//
// sequencing: idle takes the request and dispatches, then the sequencer runs one
// microcode step per cycle while the output register is free. a character runs the
// letter gap step, then a mark step per symbol with a symbol gap step between marks;
// a pad or space request runs a single pad or space step. the next request is taken
// only once the sequencer is back in idle. each segment is loaded into the output register by the step that emits it.
//
// reset clears the sequencer, the gap flag and the output valid, and sets
// the unit size to 1 and pad_len to 0. when the receiver stalls, the segment waits
// in the output register and the sequencer holds its step until the register frees.
module morse_keying_encoder_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  mke_pkg::mke_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mke_pkg::mke_out_t              out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mke_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import mke_pkg::*;

    uaddr_t            upc_reg, upc_next;
    logic [UNIT_W-1:0] unit_size_reg;
    logic [PAD_W-1:0]  pad_len_reg;
    logic              gap_reg, gap_next;
    logic [SYM_W-1:0]  sym_bits_reg, sym_bits_next;
    logic [CNT_W-1:0]  sym_cnt_reg, sym_cnt_next;
    logic              out_valid_reg, out_valid_next;
    mke_out_t          out_reg, out_next;

    ucode_t            uw;
    sym_code_t         lk;
    logic              cfg_wr;
    logic              seg_free;
    logic              step_go;
    logic              do_emit;
    logic              do_jump;
    logic [UNIT_W-1:0] unit;
    logic [DUR_W-1:0]  dur_u1, dur_u3, dur_u7;
    logic [DUR_W-1:0]  dur;

    function automatic logic cond_eval(input cond_t c, input logic pad_nz,
                                       input logic gap, input logic [CNT_W-1:0] cnt);
        logic r;
        r = 1'b0;
        unique case (c)
            C_NEVER:    r = 1'b0;
            C_ALWAYS:   r = 1'b1;
            C_PAD_NZ:   r = pad_nz;
            C_GAP:      r = gap;
            C_NO_SYM:   r = (cnt == '0);
            C_LAST_SYM: r = (cnt == CNT_W'(1));
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_UNIT_SIZE: prdata = {{(32-UNIT_W){1'b0}}, unit_size_reg};
            REG_PAD_LEN:   prdata = {{(32-PAD_W){1'b0}}, pad_len_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_size_reg <= UNIT_W'(1);
            pad_len_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_UNIT_SIZE)
            begin
                unit_size_reg <= pwdata[UNIT_W-1:0];
            end
            else
            begin
                pad_len_reg <= pwdata[PAD_W-1:0];
            end
        end
    end

    // unit multiples, a zero unit counts as one
    assign unit   = (unit_size_reg == '0) ? UNIT_W'(1) : unit_size_reg;
    assign dur_u1 = DUR_W'(unit);
    assign dur_u3 = DUR_W'({unit, 1'b0}) + DUR_W'(unit);
    assign dur_u7 = DUR_W'({unit, 3'b000}) - DUR_W'(unit);

    assign uw        = ucode_rom(upc_reg);
    assign lk        = sym_lookup(in_data.char_code);
    assign seg_free  = !out_valid_reg || out_ready;
    assign in_ready  = uw.dispatch;
    assign step_go   = !uw.dispatch && seg_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        unique case (uw.dur_sel)
            D_PAD:   dur = DUR_W'(pad_len_reg);
            D_U1:    dur = dur_u1;
            D_U3:    dur = dur_u3;
            D_U7:    dur = dur_u7;
            D_SYM:   dur = sym_bits_reg[SYM_W-1] ? dur_u3 : dur_u1;
            default: dur = dur_u1;
        endcase
    end

    always_comb
    begin
        upc_next       = upc_reg;
        gap_next       = gap_reg;
        sym_bits_next  = sym_bits_reg;
        sym_cnt_next   = sym_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        do_emit        = cond_eval(uw.emit_cond, pad_len_reg != '0, gap_reg, sym_cnt_reg);
        do_jump        = cond_eval(uw.jump_cond, pad_len_reg != '0, gap_reg, sym_cnt_reg);

        if (uw.dispatch)
        begin
            if (in_valid)
            begin
                sym_bits_next = lk.pat;
                sym_cnt_next  = lk.len;
                unique case (in_data.req_type) inside
                    REQ_START, REQ_END: upc_next = UA_PAD;
                    REQ_CHAR:
                    begin
                        upc_next = (in_data.char_code == CHAR_SPACE) ? UA_SPACE : UA_LGAP;
                    end
                    default:            upc_next = UA_IDLE;
                endcase
            end
        end
        else if (step_go)
        begin
            if (do_emit)
            begin
                out_valid_next    = 1'b1;
                out_next.level    = uw.level;
                out_next.duration = dur;
                out_next.last     = cond_eval(uw.last_cond, pad_len_reg != '0, gap_reg,
                                              sym_cnt_reg);
            end
            unique case (uw.gap_op)
                G_KEEP:  gap_next = gap_reg;
                G_CLR:   gap_next = 1'b0;
                G_SET:   gap_next = 1'b1;
                default: gap_next = gap_reg;
            endcase
            if (uw.shift)
            begin
                sym_bits_next = {sym_bits_reg[SYM_W-2:0], 1'b0};
                sym_cnt_next  = sym_cnt_reg - CNT_W'(1);
            end
            upc_next = do_jump ? uw.jump_addr : uw.next_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= UA_IDLE;
            gap_reg       <= 1'b0;
            sym_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            gap_reg       <= gap_next;
            sym_cnt_reg   <= sym_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_bits_reg <= sym_bits_next;
        out_reg      <= out_next;
    end

    // a segment marked last always hands the sequencer back to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && do_emit && out_next.last) |=> (upc_reg == UA_IDLE))
        else $error("last segment not followed by idle");

    // a non-space character always goes through the letter gap step
    a_char_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.req_type == REQ_CHAR &&
         in_data.char_code != CHAR_SPACE) |=> (upc_reg == UA_LGAP))
        else $error("character not dispatched to letter gap");

    // the symbol count never exceeds the longest code
    a_sym_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        sym_cnt_reg <= CNT_W'(SYM_W))
        else $error("symbol count out of range");

    // marks are only produced while symbols remain
    a_mark_has_sym: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == UA_MARK) |-> (sym_cnt_reg != '0))
        else $error("mark step with no symbol left");

    // a stalled segment is not overwritten by the sequencer
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(out_reg))
        else $error("pending segment overwritten");

endmodule
